// ----- src/mtsg_pkg.sv -----
package mtsg_pkg;

   // Default store depth and fixed field widths.
   localparam int MAX_VERTICES_DEFAULT = 256;
   localparam int INDEX_W              = 8;
   localparam int Q_W                  = 32;
   localparam int REQ_DATA_W           = 280;
   localparam int RSP_DATA_W           = 104;

   // Fixed-point 1.0 in Q16.16.
   localparam logic signed [Q_W-1:0] Q_ONE = 32'sh0001_0000;

   // Iteration counts of the serial divider and square root.
   localparam int DIV_STEPS  = 48;
   localparam int SQRT_STEPS = 32;

   typedef enum logic [1:0] {
      OP_LOAD     = 2'd0,
      OP_TRIANGLE = 2'd1,
      OP_READ     = 2'd2,
      OP_CLEAR    = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_VRD,
      ST_SQ,
      ST_SQRT,
      ST_DET,
      ST_DIV,
      ST_TB,
      ST_ACC,
      ST_RRD,
      ST_RMUL,
      ST_RSP
   } state_type;

endpackage

// ----- src/mesh_tangent_space_generator_top.sv -----
// Per-vertex tangent space generator in Q16.16 fixed point. An item on the request
// stream loads a vertex, adds one triangle to the tangent and bitangent sums of its
// three corners, reads one vertex's orthogonalized tangent with its handedness, or
// clears all sums. Vertices live in one synchronous memory and the sums in another;
// a read-modify-write per corner keeps repeated corners correct, and a clear works
// through per-entry valid bits. A triangle passes through vertex fetch, determinant,
// reciprocal, products and sum updates, or, when the first u delta is zero, through
// vertex fetch, squares, square root, three divides and sum updates; a degenerate
// triangle ends early. A read fetches, projects and then offers its result item,
// later while an earlier result stalls. All products come from the single shared
// 32x32 multiplier, quotients from the one-bit-per-cycle divider and roots from the
// two-bit-per-cycle square root.
module mesh_tangent_space_generator_top #(
   parameter int MAX_VERTICES = mtsg_pkg::MAX_VERTICES_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // index_a, index_b, index_c, pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z, tex_u, tex_v
   input  logic [mtsg_pkg::REQ_DATA_W-1:0]     req_tdata,
   // opcode
   input  logic [1:0]                          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // tan_x, tan_y, tan_z, handed_negative, zero fill
   output logic [mtsg_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   localparam int DEPTH = (MAX_VERTICES < 256) ? MAX_VERTICES : 256;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(mtsg_pkg::DIV_STEPS + 1);

   typedef logic [AW-1:0] lut_type [256];

   // Index to store address, reduced modulo the vertex count.
   function automatic lut_type build_lut();
      lut_type lut;
      for (int i = 0; i < 256; i++) begin
         lut[i] = AW'(i % MAX_VERTICES);
      end
      return lut;
   endfunction

   localparam lut_type MOD_LUT = build_lut();

   function automatic logic signed [31:0] sat_q(input logic signed [47:0] v);
      if (v > 48'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (v < -48'sd2147483648) begin
         return 32'sh80000000;
      end
      return $signed(v[31:0]);
   endfunction

   function automatic logic signed [31:0] sub_sat(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
      logic signed [47:0] wa;
      logic signed [47:0] wb;
      wa = 48'(a);
      wb = 48'(b);
      return sat_q(wa - wb);
   endfunction

   function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
      logic signed [47:0] wa;
      logic signed [47:0] wb;
      wa = 48'(a);
      wb = 48'(b);
      return sat_q(wa + wb);
   endfunction

   function automatic logic [31:0] abs_q(input logic signed [31:0] v);
      return v[31] ? (~v + 32'd1) : v;
   endfunction

   // Control registers.
   mtsg_pkg::state_type state_ff, state_in;
   logic             phase_ff, phase_in;
   logic [1:0]       k_ff, k_in;
   logic [3:0]       step_ff, step_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             fall_ff, fall_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [DEPTH-1:0] vld_ff;

   // Payload registers.
   logic [AW-1:0]      addr_a_ff, addr_a_in, addr_b_ff, addr_b_in, addr_c_ff, addr_c_in;
   logic signed [31:0] p0_ff [3], p0_in [3];
   logic signed [31:0] u0_ff, u0_in, v0_ff, v0_in;
   logic signed [31:0] e1_ff [3], e1_in [3];
   logic signed [31:0] e2_ff [3], e2_in [3];
   logic signed [31:0] du1_ff, du1_in, dv1_ff, dv1_in, du2_ff, du2_in, dv2_ff, dv2_in;
   logic signed [31:0] q_ff, q_in, s_ff, s_in, r_ff, r_in, d_ff, d_in;
   logic signed [31:0] tv_ff [3], tv_in [3];
   logic signed [31:0] bv_ff [3], bv_in [3];
   logic signed [31:0] nv_ff [3], nv_in [3];
   logic signed [31:0] cr_ff [3], cr_in [3];
   logic signed [31:0] ov_ff [3], ov_in [3];
   logic signed [33:0] dacc_ff, dacc_in;
   logic               hneg_ff, hneg_in;
   logic [63:0]        sq_ff, sq_in, res_ff, res_in, bit_ff, bit_in;
   logic [31:0]        rem_ff, rem_in, dmag_ff, dmag_in;
   logic [47:0]        numq_ff, numq_in;
   logic               dneg_ff, dneg_in;
   logic [95:0]        rtan_ff, rtan_in;
   logic               rneg_ff, rneg_in;

   // Shared multiplier.
   logic signed [31:0] opa, opb, mq;
   logic signed [63:0] prod_ff;

   // Memory ports.
   logic [255:0] vtx_mem [DEPTH];
   logic [191:0] acc_mem [DEPTH];
   logic [255:0] vtx_rd_ff, vtx_wdata;
   logic [191:0] acc_rd_ff, acc_wdata;
   logic         acc_vld_rd_ff;
   logic         vtx_we, acc_we, vld_clr;
   logic [AW-1:0] vtx_waddr, corner;

   // Request decode.
   logic              req_acc;
   mtsg_pkg::op_type  req_op;
   logic [AW-1:0]     map_a, map_b, map_c;

   // Divider start and result.
   logic               start_div;
   logic signed [31:0] sd_num;
   logic [31:0]        sd_den;
   logic               sd_dneg;
   logic signed [31:0] div_res;
   logic [32:0]        rem_sh;

   // Square root step.
   logic [63:0] sq_trial;

   // Accumulator word fields of the old value.
   logic signed [31:0] old_t [3], old_b [3];

   assign req_tready = (state_ff == mtsg_pkg::ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign req_op     = mtsg_pkg::op_type'(req_tuser);
   assign map_a      = MOD_LUT[req_tdata[7:0]];
   assign map_b      = MOD_LUT[req_tdata[15:8]];
   assign map_c      = MOD_LUT[req_tdata[23:16]];

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rneg_ff, rtan_ff};

   // Corner address for the current corner counter.
   always_comb begin
      case (k_ff)
         2'd0:    corner = addr_a_ff;
         2'd1:    corner = addr_b_ff;
         default: corner = addr_c_ff;
      endcase
   end

   // Multiplier operand selection.
   always_comb begin
      opa = '0;
      opb = '0;
      case (state_ff)
         mtsg_pkg::ST_SQ: begin
            opa = e1_ff[k_ff];
            opb = e1_ff[k_ff];
         end
         mtsg_pkg::ST_DET: begin
            if (step_ff == 4'd0) begin
               opa = du1_ff;
               opb = dv2_ff;
            end else begin
               opa = dv1_ff;
               opb = du2_ff;
            end
         end
         mtsg_pkg::ST_TB: begin
            case (step_ff)
               4'd0:    begin opa = e1_ff[k_ff]; opb = dv2_ff; end
               4'd1:    begin opa = e2_ff[k_ff]; opb = dv1_ff; end
               4'd3:    begin opa = e2_ff[k_ff]; opb = du1_ff; end
               4'd4:    begin opa = e1_ff[k_ff]; opb = du2_ff; end
               default: begin opa = s_ff;        opb = r_ff;   end
            endcase
         end
         mtsg_pkg::ST_RMUL: begin
            case (step_ff)
               4'd0:    begin opa = nv_ff[0]; opb = tv_ff[0]; end
               4'd1:    begin opa = nv_ff[1]; opb = tv_ff[1]; end
               4'd2:    begin opa = nv_ff[2]; opb = tv_ff[2]; end
               4'd3:    begin opa = nv_ff[1]; opb = tv_ff[2]; end
               4'd4:    begin opa = nv_ff[2]; opb = tv_ff[1]; end
               4'd5:    begin opa = nv_ff[2]; opb = tv_ff[0]; end
               4'd6:    begin opa = nv_ff[0]; opb = tv_ff[2]; end
               4'd7:    begin opa = nv_ff[0]; opb = tv_ff[1]; end
               4'd8:    begin opa = nv_ff[1]; opb = tv_ff[0]; end
               4'd9:    begin opa = cr_ff[0]; opb = bv_ff[0]; end
               4'd10:   begin opa = cr_ff[1]; opb = bv_ff[1]; end
               4'd11:   begin opa = cr_ff[2]; opb = bv_ff[2]; end
               4'd12:   begin opa = nv_ff[0]; opb = d_ff;     end
               4'd13:   begin opa = nv_ff[1]; opb = d_ff;     end
               default: begin opa = nv_ff[2]; opb = d_ff;     end
            endcase
         end
         default: begin
            opa = '0;
            opb = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= opa * opb;
   end

   // Product shifted down with floor rounding, then saturated.
   assign mq = sat_q($signed(prod_ff[63:16]));

   // Signed quotient with saturation from the divider magnitude.
   always_comb begin
      if (dneg_ff) begin
         div_res = (numq_ff > 48'd2147483648) ? 32'sh80000000 : $signed(32'(-numq_ff));
      end else begin
         div_res = (numq_ff > 48'd2147483647) ? 32'sh7fffffff : $signed(numq_ff[31:0]);
      end
   end

   assign rem_sh   = {rem_ff, numq_ff[47]};
   assign sq_trial = res_ff + bit_ff;

   // Old accumulator values, zero when the entry was cleared.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         old_t[i] = acc_vld_rd_ff ? $signed(acc_rd_ff[32*i +: 32]) : 32'sd0;
         old_b[i] = acc_vld_rd_ff ? $signed(acc_rd_ff[96 + 32*i +: 32]) : 32'sd0;
      end
   end

   // Sequencer: next state and datapath updates.
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      k_in         = k_ff;
      step_in      = step_ff;
      cnt_in       = cnt_ff;
      fall_in      = fall_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      addr_a_in    = addr_a_ff;
      addr_b_in    = addr_b_ff;
      addr_c_in    = addr_c_ff;
      p0_in        = p0_ff;
      u0_in        = u0_ff;
      v0_in        = v0_ff;
      e1_in        = e1_ff;
      e2_in        = e2_ff;
      du1_in       = du1_ff;
      dv1_in       = dv1_ff;
      du2_in       = du2_ff;
      dv2_in       = dv2_ff;
      q_in         = q_ff;
      s_in         = s_ff;
      r_in         = r_ff;
      d_in         = d_ff;
      tv_in        = tv_ff;
      bv_in        = bv_ff;
      nv_in        = nv_ff;
      cr_in        = cr_ff;
      ov_in        = ov_ff;
      dacc_in      = dacc_ff;
      hneg_in      = hneg_ff;
      sq_in        = sq_ff;
      res_in       = res_ff;
      bit_in       = bit_ff;
      rem_in       = rem_ff;
      dmag_in      = dmag_ff;
      numq_in      = numq_ff;
      dneg_in      = dneg_ff;
      rtan_in      = rtan_ff;
      rneg_in      = rneg_ff;
      vtx_we       = 1'b0;
      vtx_waddr    = map_a;
      vtx_wdata    = req_tdata[279:24];
      acc_we       = 1'b0;
      acc_wdata    = '0;
      vld_clr      = 1'b0;
      start_div    = 1'b0;
      sd_num       = '0;
      sd_den       = '0;
      sd_dneg      = 1'b0;

      case (state_ff)
         mtsg_pkg::ST_IDLE: begin
            if (req_acc) begin
               addr_a_in = map_a;
               addr_b_in = map_b;
               addr_c_in = map_c;
               phase_in  = 1'b0;
               k_in      = 2'd0;
               case (req_op)
                  mtsg_pkg::OP_LOAD:     vtx_we   = 1'b1;
                  mtsg_pkg::OP_TRIANGLE: state_in = mtsg_pkg::ST_VRD;
                  mtsg_pkg::OP_READ:     state_in = mtsg_pkg::ST_RRD;
                  mtsg_pkg::OP_CLEAR:    vld_clr  = 1'b1;
                  default:               state_in = mtsg_pkg::ST_IDLE;
               endcase
            end
         end

         // Fetch the three corners and form edges and uv deltas.
         mtsg_pkg::ST_VRD: begin
            phase_in = !phase_ff;
            if (phase_ff) begin
               case (k_ff)
                  2'd0: begin
                     for (int i = 0; i < 3; i++) begin
                        p0_in[i] = $signed(vtx_rd_ff[32*i +: 32]);
                     end
                     u0_in = $signed(vtx_rd_ff[223:192]);
                     v0_in = $signed(vtx_rd_ff[255:224]);
                  end
                  2'd1: begin
                     for (int i = 0; i < 3; i++) begin
                        e1_in[i] = sub_sat($signed(vtx_rd_ff[32*i +: 32]), p0_ff[i]);
                     end
                     du1_in = sub_sat($signed(vtx_rd_ff[223:192]), u0_ff);
                     dv1_in = sub_sat($signed(vtx_rd_ff[255:224]), v0_ff);
                  end
                  default: begin
                     for (int i = 0; i < 3; i++) begin
                        e2_in[i] = sub_sat($signed(vtx_rd_ff[32*i +: 32]), p0_ff[i]);
                     end
                     du2_in = sub_sat($signed(vtx_rd_ff[223:192]), u0_ff);
                     dv2_in = sub_sat($signed(vtx_rd_ff[255:224]), v0_ff);
                  end
               endcase
               k_in = k_ff + 2'd1;
               if (k_ff == 2'd2) begin
                  k_in    = 2'd0;
                  step_in = '0;
                  fall_in = (du1_ff == 32'sd0);
                  sq_in   = '0;
                  state_in = (du1_ff == 32'sd0) ? mtsg_pkg::ST_SQ : mtsg_pkg::ST_DET;
               end
            end
         end

         // Sum of squares of the first edge.
         mtsg_pkg::ST_SQ: begin
            phase_in = !phase_ff;
            if (phase_ff) begin
               sq_in = sq_ff + $unsigned(prod_ff);
               k_in  = k_ff + 2'd1;
               if (k_ff == 2'd2) begin
                  k_in     = 2'd0;
                  res_in   = '0;
                  bit_in   = 64'd1 << 62;
                  cnt_in   = '0;
                  state_in = mtsg_pkg::ST_SQRT;
               end
            end
         end

         // Floor square root, two bits of the radicand per cycle.
         mtsg_pkg::ST_SQRT: begin
            if (cnt_ff != CW'(mtsg_pkg::SQRT_STEPS)) begin
               if (sq_ff >= sq_trial) begin
                  sq_in  = sq_ff - sq_trial;
                  res_in = (res_ff >> 1) + bit_ff;
               end else begin
                  res_in = res_ff >> 1;
               end
               bit_in = bit_ff >> 2;
               cnt_in = cnt_ff + CW'(1);
            end else if (res_ff == 64'd0) begin
               state_in = mtsg_pkg::ST_IDLE;
            end else begin
               start_div = 1'b1;
               sd_num    = e1_ff[0];
               sd_den    = res_ff[31:0];
               sd_dneg   = e1_ff[0][31];
               k_in      = 2'd0;
               state_in  = mtsg_pkg::ST_DIV;
            end
         end

         // Determinant of the uv deltas.
         mtsg_pkg::ST_DET: begin
            phase_in = !phase_ff;
            if (phase_ff) begin
               if (step_ff == 4'd0) begin
                  q_in    = mq;
                  step_in = 4'd1;
               end else begin
                  step_in = '0;
                  if (sub_sat(q_ff, mq) == 32'sd0) begin
                     state_in = mtsg_pkg::ST_IDLE;
                  end else begin
                     start_div = 1'b1;
                     sd_num    = mtsg_pkg::Q_ONE;
                     sd_den    = abs_q(sub_sat(q_ff, mq));
                     sd_dneg   = sub_sat(q_ff, mq) < 32'sd0;
                     state_in  = mtsg_pkg::ST_DIV;
                  end
               end
            end
         end

         // Restoring division, one quotient bit per cycle.
         mtsg_pkg::ST_DIV: begin
            if (cnt_ff != CW'(mtsg_pkg::DIV_STEPS)) begin
               if (rem_sh >= {1'b0, dmag_ff}) begin
                  rem_in  = 32'(rem_sh - {1'b0, dmag_ff});
                  numq_in = {numq_ff[46:0], 1'b1};
               end else begin
                  rem_in  = rem_sh[31:0];
                  numq_in = {numq_ff[46:0], 1'b0};
               end
               cnt_in = cnt_ff + CW'(1);
            end else if (fall_ff) begin
               tv_in[k_ff] = div_res;
               bv_in[k_ff] = '0;
               if (k_ff == 2'd2) begin
                  k_in     = 2'd0;
                  phase_in = 1'b0;
                  state_in = mtsg_pkg::ST_ACC;
               end else begin
                  k_in      = k_ff + 2'd1;
                  start_div = 1'b1;
                  sd_num    = e1_ff[k_ff + 2'd1];
                  sd_den    = res_ff[31:0];
                  sd_dneg   = e1_ff[k_ff + 2'd1][31];
               end
            end else begin
               r_in     = div_res;
               k_in     = 2'd0;
               step_in  = '0;
               phase_in = 1'b0;
               state_in = mtsg_pkg::ST_TB;
            end
         end

         // Tangent and bitangent of the face, one component per six products.
         mtsg_pkg::ST_TB: begin
            phase_in = !phase_ff;
            if (phase_ff) begin
               step_in = step_ff + 4'd1;
               case (step_ff)
                  4'd0:    q_in = mq;
                  4'd1:    s_in = sub_sat(q_ff, mq);
                  4'd2:    tv_in[k_ff] = mq;
                  4'd3:    q_in = mq;
                  4'd4:    s_in = sub_sat(q_ff, mq);
                  default: begin
                     bv_in[k_ff] = mq;
                     step_in     = '0;
                     k_in        = k_ff + 2'd1;
                     if (k_ff == 2'd2) begin
                        k_in     = 2'd0;
                        state_in = mtsg_pkg::ST_ACC;
                     end
                  end
               endcase
            end
         end

         // Read-modify-write of each corner's sums; the next read follows the write.
         mtsg_pkg::ST_ACC: begin
            phase_in = !phase_ff;
            if (phase_ff) begin
               acc_we = 1'b1;
               for (int i = 0; i < 3; i++) begin
                  acc_wdata[32*i +: 32]      = add_sat(old_t[i], tv_ff[i]);
                  acc_wdata[96 + 32*i +: 32] = add_sat(old_b[i], bv_ff[i]);
               end
               k_in = k_ff + 2'd1;
               if (k_ff == 2'd2) begin
                  k_in     = 2'd0;
                  state_in = mtsg_pkg::ST_IDLE;
               end
            end
         end

         // Fetch normal and sums of the vertex to read.
         mtsg_pkg::ST_RRD: begin
            phase_in = !phase_ff;
            if (phase_ff) begin
               for (int i = 0; i < 3; i++) begin
                  nv_in[i] = $signed(vtx_rd_ff[96 + 32*i +: 32]);
                  tv_in[i] = old_t[i];
                  bv_in[i] = old_b[i];
               end
               step_in  = '0;
               state_in = mtsg_pkg::ST_RMUL;
            end
         end

         // Projection onto the tangent plane and handedness sign.
         mtsg_pkg::ST_RMUL: begin
            phase_in = !phase_ff;
            if (phase_ff) begin
               step_in = step_ff + 4'd1;
               case (step_ff)
                  4'd0:  dacc_in = 34'(mq);
                  4'd1:  dacc_in = dacc_ff + 34'(mq);
                  4'd2:  d_in = sat_q(48'(dacc_ff + 34'(mq)));
                  4'd3:  q_in = mq;
                  4'd4:  cr_in[0] = sub_sat(q_ff, mq);
                  4'd5:  q_in = mq;
                  4'd6:  cr_in[1] = sub_sat(q_ff, mq);
                  4'd7:  q_in = mq;
                  4'd8:  cr_in[2] = sub_sat(q_ff, mq);
                  4'd9:  dacc_in = 34'(mq);
                  4'd10: dacc_in = dacc_ff + 34'(mq);
                  4'd11: hneg_in = (dacc_ff + 34'(mq)) < 34'sd0;
                  4'd12: ov_in[0] = sub_sat(tv_ff[0], mq);
                  4'd13: ov_in[1] = sub_sat(tv_ff[1], mq);
                  default: begin
                     ov_in[2] = sub_sat(tv_ff[2], mq);
                     step_in  = '0;
                     state_in = mtsg_pkg::ST_RSP;
                  end
               endcase
            end
         end

         // Hand the result to the output register once it is free.
         mtsg_pkg::ST_RSP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rtan_in      = {ov_ff[2], ov_ff[1], ov_ff[0]};
               rneg_in      = hneg_ff;
               rsp_valid_in = 1'b1;
               state_in     = mtsg_pkg::ST_IDLE;
            end
         end

         default: state_in = mtsg_pkg::ST_IDLE;
      endcase

      // Divider load, shared by the reciprocal and the edge normalization.
      if (start_div) begin
         rem_in  = '0;
         numq_in = {abs_q(sd_num), 16'd0};
         dmag_in = sd_den;
         dneg_in = sd_dneg;
         cnt_in  = '0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mtsg_pkg::ST_IDLE;
         phase_ff     <= 1'b0;
         k_ff         <= 2'd0;
         step_ff      <= '0;
         cnt_ff       <= '0;
         fall_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         vld_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         k_ff         <= k_in;
         step_ff      <= step_in;
         cnt_ff       <= cnt_in;
         fall_ff      <= fall_in;
         rsp_valid_ff <= rsp_valid_in;
         if (vld_clr) begin
            vld_ff <= '0;
         end else if (acc_we) begin
            vld_ff[corner] <= 1'b1;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      addr_a_ff <= addr_a_in;
      addr_b_ff <= addr_b_in;
      addr_c_ff <= addr_c_in;
      p0_ff     <= p0_in;
      u0_ff     <= u0_in;
      v0_ff     <= v0_in;
      e1_ff     <= e1_in;
      e2_ff     <= e2_in;
      du1_ff    <= du1_in;
      dv1_ff    <= dv1_in;
      du2_ff    <= du2_in;
      dv2_ff    <= dv2_in;
      q_ff      <= q_in;
      s_ff      <= s_in;
      r_ff      <= r_in;
      d_ff      <= d_in;
      tv_ff     <= tv_in;
      bv_ff     <= bv_in;
      nv_ff     <= nv_in;
      cr_ff     <= cr_in;
      ov_ff     <= ov_in;
      dacc_ff   <= dacc_in;
      hneg_ff   <= hneg_in;
      sq_ff     <= sq_in;
      res_ff    <= res_in;
      bit_ff    <= bit_in;
      rem_ff    <= rem_in;
      dmag_ff   <= dmag_in;
      numq_ff   <= numq_in;
      dneg_ff   <= dneg_in;
      rtan_ff   <= rtan_in;
      rneg_ff   <= rneg_in;
   end

   // Vertex store: written by loads, read at the current corner.
   always_ff @(posedge clock) begin
      if (vtx_we) begin
         vtx_mem[vtx_waddr] <= vtx_wdata;
      end
      vtx_rd_ff <= vtx_mem[corner];
   end

   // Sum store with its valid bit read alongside.
   always_ff @(posedge clock) begin
      if (acc_we) begin
         acc_mem[corner] <= acc_wdata;
      end
      acc_rd_ff     <= acc_mem[corner];
      acc_vld_rd_ff <= vld_ff[corner];
   end

`ifndef ASSERT_OFF
   // A result is loaded only from the hand-off state.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == mtsg_pkg::ST_RSP))
      else $error("result loaded outside the hand-off state");

   // A clear leaves every entry reading as zero.
   a_clear_all: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_op == mtsg_pkg::OP_CLEAR) |=> (vld_ff == '0))
      else $error("clear left valid entries");

   // The corner counter never selects a fourth corner.
   a_corner_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != mtsg_pkg::ST_IDLE) |-> (k_ff != 2'd3))
      else $error("corner counter out of range");

   // Sums are written only during the corner update.
   a_acc_write: assert property (@(posedge clock) disable iff (reset)
      acc_we |-> (state_ff == mtsg_pkg::ST_ACC && phase_ff))
      else $error("sum store written outside the corner update");
`endif

endmodule
